>>> src/evs_pkg.sv
// ----------------------------------------------------------------------------
// evs_pkg: shared types for the ensemble vector spread block
// Transaction structs, the internal operation record and the back-end states.
// ----------------------------------------------------------------------------
package evs_pkg;

  localparam int unsigned PointW  = 14;
  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 24;
  localparam int unsigned SqSumW  = 41;
  localparam int unsigned SqW     = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned SpreadW = 16;

  localparam logic REQ_ACCUM   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [PointW-1:0]         point_index;
    logic signed [SampleW-1:0] u_sample;
    logic signed [SampleW-1:0] v_sample;
    logic                      sample_missing;
  } in_item_t;

  typedef struct packed {
    logic [PointW-1:0]  result_point;
    logic [SpreadW-1:0] spread;
    logic               spread_missing;
  } out_item_t;

  // One classified request as the front end hands it to the back end.
  typedef struct packed {
    logic                      req_type;
    logic [PointW-1:0]         point;
    logic signed [SampleW-1:0] u;
    logic signed [SampleW-1:0] v;
    logic [SqW-1:0]            sq;
    logic                      missing;
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MUL,
    S_NUM,
    S_DIV,
    S_SQRT,
    S_OUT
  } back_state_t;

endpackage

>>> src/evs_front.sv
// ----------------------------------------------------------------------------
// evs_front: request intake
// Drops requests beyond the grid, sums the squares of both samples and queues the operation.
// ----------------------------------------------------------------------------
module evs_front #(
  parameter int unsigned GRID_POINTS = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  evs_pkg::in_item_t item,
  output logic              q_full,
  output logic              op_valid,
  output evs_pkg::op_t      op,
  input  logic              op_pop
);
  import evs_pkg::*;

  localparam int unsigned CmpW = (PointW > $clog2(GRID_POINTS + 1)) ? PointW
                                 : $clog2(GRID_POINTS + 1);

  op_t        ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  op_t        new_op;
  logic       in_range;
  logic       enq;
  logic       deq;
  logic signed [2*SampleW-1:0] uu, vv;

  assign in_range = CmpW'(item.point_index) < CmpW'(GRID_POINTS);
  assign enq      = push && in_range;
  assign deq      = op_pop && op_valid;
  assign uu       = item.u_sample * item.u_sample;
  assign vv       = item.v_sample * item.v_sample;

  always_comb begin
    new_op.req_type = item.req_type;
    new_op.point    = item.point_index;
    new_op.u        = item.u_sample;
    new_op.v        = item.v_sample;
    new_op.sq       = SqW'(uu) + SqW'(vv);
    new_op.missing  = item.sample_missing;
  end

  always_comb begin
    wr_ptr_nxt = enq ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = deq ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(enq) - 2'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      ent_r[wr_ptr_r] <= new_op;
    end
  end

  assign q_full   = cnt_r == 2'd2;
  assign op_valid = cnt_r != 2'd0;
  assign op       = ent_r[rd_ptr_r];

endmodule

>>> src/evs_back.sv
// ----------------------------------------------------------------------------
// evs_back: accumulator memory and spread computation
// Read-modify-write of per-point sums; compute clears the point and, unless skipped, runs divide and root serially.
// ----------------------------------------------------------------------------
module evs_back #(
  parameter int unsigned GRID_POINTS = 16384
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [evs_pkg::CountW-1:0]      member_count,
  input  logic                            op_valid,
  input  evs_pkg::op_t                    op,
  output logic                            op_pop,
  output logic                            clearing,
  output logic                            res_valid,
  output evs_pkg::out_item_t              res,
  input  logic                            res_pop
);
  import evs_pkg::*;

  localparam int unsigned AW   = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int unsigned EntW = 2 * SumW + SqSumW + 1;
  localparam int unsigned DivN = 49;
  localparam int unsigned DivW = 2 * CountW;
  localparam int unsigned RootW = (DivN + 1) / 2;
  localparam int unsigned RemW = RootW + 3;

  typedef struct packed {
    logic [SumW-1:0]   su;
    logic [SumW-1:0]   sv;
    logic [SqSumW-1:0] sq;
    logic              miss;
  } ent_t;

  logic [EntW-1:0] mem [GRID_POINTS];
  ent_t            rd_r;
  ent_t            wr_ent;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;

  back_state_t state_r, state_nxt;
  logic [AW-1:0]   clr_r;
  op_t             op_r;
  logic signed [SumW-1:0] su_r, sv_r;
  logic [SqSumW-1:0] sq_r;
  logic            miss_r;
  logic [2*SumW-1:0] pu_r, pv_r;
  logic [SqSumW+CountW-1:0] pn_r;
  logic signed [SqSumW+CountW+1:0] num;
  logic [DivN-1:0] dq_r;
  logic [DivW:0]   drem_r;
  logic [DivW:0]   drem_sh;
  logic [DivW-1:0] dvs_r;
  logic [5:0]      cnt_r;
  logic [2*RootW-1:0] x_r;
  logic [RemW-1:0] srem_r;
  logic [RootW-1:0] root_r;
  logic [SpreadW-1:0] spread_r;
  logic            smiss_r;
  logic            last;

  assign num = $signed({2'b00, pn_r}) - $signed({3'b000, pu_r + pv_r});
  assign drem_sh = {drem_r[DivW-1:0], dq_r[DivN-1]};
  assign last    = cnt_r == 6'd1;

  // Next state and memory write control.
  always_comb begin
    state_nxt = state_r;
    op_pop    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = AW'(op_r.point);
    wr_ent    = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        if (clr_r == AW'(GRID_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_valid) begin
          op_pop    = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        wr_en = 1'b1;
        if (op_r.req_type == REQ_ACCUM) begin
          wr_ent = rd_r;
          if (op_r.missing) begin
            wr_ent.miss = 1'b1;
          end else begin
            wr_ent.su = rd_r.su + SumW'(op_r.u);
            wr_ent.sv = rd_r.sv + SumW'(op_r.v);
            wr_ent.sq = rd_r.sq + SqSumW'(op_r.sq);
          end
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_NUM;
      S_NUM: begin
        if (miss_r || member_count < CountW'(2) || num <= 0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:  if (last) state_nxt = S_SQRT;
      S_SQRT: if (last) state_nxt = S_OUT;
      S_OUT: begin
        if (!res_valid || res_pop) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    rd_r <= mem[AW'(op.point)];
  end

  // Datapath registers, loaded by state.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (op_valid) op_r <= op;
      S_READ: begin
        su_r   <= rd_r.su;
        sv_r   <= rd_r.sv;
        sq_r   <= rd_r.sq;
        miss_r <= rd_r.miss;
      end
      S_MUL: begin
        pu_r <= (2*SumW)'(su_r * su_r);
        pv_r <= (2*SumW)'(sv_r * sv_r);
        pn_r <= member_count * sq_r;
      end
      S_NUM: begin
        smiss_r  <= miss_r || member_count < CountW'(2);
        dq_r     <= num[DivN-1:0];
        drem_r   <= '0;
        dvs_r    <= DivW'(member_count * (member_count - CountW'(1)));
        cnt_r    <= 6'(DivN);
      end
      S_DIV: begin
        if (drem_sh >= {1'b0, dvs_r}) begin
          drem_r <= drem_sh - {1'b0, dvs_r};
          dq_r   <= {dq_r[DivN-2:0], 1'b1};
        end else begin
          drem_r <= drem_sh;
          dq_r   <= {dq_r[DivN-2:0], 1'b0};
        end
        if (last) begin
          cnt_r <= 6'(RootW);
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
      S_SQRT: begin
        cnt_r <= cnt_r - 6'd1;
      end
      default: ;
    endcase
  end

  // Square root: on its first cycle the quotient is taken straight from dq_r.
  logic [2*RootW-1:0] x_cur;
  logic [RemW-1:0]    rem_cur, rem_shc;
  logic [RootW-1:0]   root_cur;
  logic               first_sq;

  assign first_sq = cnt_r == 6'(RootW);
  assign x_cur    = first_sq ? (2*RootW)'(dq_r) : x_r;
  assign rem_cur  = first_sq ? '0 : srem_r;
  assign root_cur = first_sq ? '0 : root_r;
  assign rem_shc  = {rem_cur[RemW-3:0], x_cur[2*RootW-1 -: 2]};

  always_ff @(posedge clk) begin
    if (state_r == S_NUM) begin
      spread_r <= '0;
    end
    if (state_r == S_SQRT) begin
      x_r <= {x_cur[2*RootW-3:0], 2'b00};
      if (rem_shc >= {1'b0, root_cur, 2'b01}) begin
        srem_r <= rem_shc - {1'b0, root_cur, 2'b01};
        root_r <= {root_cur[RootW-2:0], 1'b1};
      end else begin
        srem_r <= rem_shc;
        root_r <= {root_cur[RootW-2:0], 1'b0};
      end
    end
    if (state_r == S_SQRT && last) begin
      if (rem_shc >= {1'b0, root_cur, 2'b01}) begin
        spread_r <= (root_cur[RootW-2:SpreadW-1] != '0) ? '1
                    : {root_cur[SpreadW-2:0], 1'b1};
      end else begin
        spread_r <= (root_cur[RootW-2:SpreadW-1] != '0) ? '1
                    : {root_cur[SpreadW-2:0], 1'b0};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else if (state_r == S_OUT && (!res_valid || res_pop)) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!res_valid || res_pop)) begin
      res.result_point   <= op_r.point;
      res.spread         <= smiss_r ? '0 : spread_r;
      res.spread_missing <= smiss_r;
    end
  end

  assign clearing = state_r == S_CLEAR;

endmodule

>>> src/ensemble_vector_spread.sv
// ----------------------------------------------------------------------------
// ensemble_vector_spread: per-point ensemble spread of a 2-D vector
// Accumulates member (u, v) samples per grid point and reports the spread.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_push / in_full    in_item_t request
//  out_     output     out_empty / out_pop  out_item_t spread result
//  cfg_     input      cfg_valid/cfg_ready  member count n
//
// An accumulate transaction in the back end pops the queue with the memory
// read, then does the read-modify-write of the point's accumulators.
// A compute transaction runs the bit-serial divider (49 steps), then the
// digit-serial square root (25 steps); a missing point, a count below two or
// a variance of zero or less skips both.
// After reset a clearing pass writes zero to all GRID_POINTS entries, one a
// cycle; in_full stays high for the whole pass.
// A full result register stalls the back end; the two-entry front queue keeps
// taking requests until it fills.
//
module ensemble_vector_spread #(
  parameter int unsigned GRID_POINTS = 16384
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  evs_pkg::in_item_t            in_data,
  output logic                         out_empty,
  input  logic                         out_pop,
  output evs_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [evs_pkg::CountW-1:0]   cfg_data
);
  import evs_pkg::*;

  logic [CountW-1:0] n_r;
  logic              q_full;
  logic              op_valid;
  op_t               op;
  logic              op_pop;
  logic              clearing;
  logic              res_valid;

  // The member count register can always take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= CountW'(2);
    end else if (cfg_valid) begin
      n_r <= cfg_data;
    end
  end

  // No requests are taken while the accumulator memory is being cleared.
  assign in_full = q_full || clearing;

  evs_front #(.GRID_POINTS(GRID_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push && !in_full),
    .item     (in_data),
    .q_full   (q_full),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  evs_back #(.GRID_POINTS(GRID_POINTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .member_count (n_r),
    .op_valid     (op_valid),
    .op           (op),
    .op_pop       (op_pop),
    .clearing     (clearing),
    .res_valid    (res_valid),
    .res          (out_data),
    .res_pop      (out_pop)
  );

  assign out_empty = !res_valid;

endmodule

>>> src/evs_checker.sv
// ----------------------------------------------------------------------------
// evs_checker: port-level checks for ensemble_vector_spread
// Reset behavior, result stability and cfg_ready, attached to the top level by bind.
// ----------------------------------------------------------------------------
module evs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input evs_pkg::out_item_t out_data,
  input logic               cfg_ready
);
  import evs_pkg::*;

  // The clearing pass holds off requests right after reset.
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("request taken during clearing pass");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind ensemble_vector_spread evs_checker u_evs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

>>> dv/tb_ensemble_vector_spread.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ensemble_vector_spread: self-checking bench for the vector spread block
// Requests are driven from a queue of pending items. Each accepted request
// updates a per-point model of the u, v and square sums. Each compute request
// queues the spread it must return, and the monitor checks every popped
// result against that queue, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ensemble_vector_spread;
  import evs_pkg::*;

  localparam int unsigned Points = 16384;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CountW-1:0] cfg_data = '0;

  // Requests waiting to be sent; the head stays here until it is accepted.
  in_item_t  pending_reqs[$];
  // Spread results that the block still owes, oldest first.
  out_item_t owed_spreads[$];

  // Mirror of the block's per-point accumulators and its member count.
  logic [SumW-1:0]   sum_u_mirror[Points];
  logic [SumW-1:0]   sum_v_mirror[Points];
  logic [SqSumW-1:0] sum_sq_mirror[Points];
  logic              missing_mirror[Points];
  logic [CountW-1:0] members_n = 8'd2;

  int  send_gap = 0;
  int  pop_gap = 0;
  bit  quiet = 1'b0;   // no idling in the last part of the run
  int  errors = 0;

  always #10 clk = ~clk;

  ensemble_vector_spread i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Integer square root, floor of the exact root.
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Applies one accepted request to the mirror; a compute request also
  // queues the result it must produce and clears the point.
  task automatic apply_request(input in_item_t req);
    int unsigned     p;
    longint          u, v, su, sv, num;
    longint unsigned n, q, root;
    out_item_t       res;
    p = req.point_index;
    if (p >= Points) return;
    if (req.req_type == REQ_ACCUM) begin
      if (req.sample_missing) begin
        missing_mirror[p] = 1'b1;
      end else begin
        u = req.u_sample;
        v = req.v_sample;
        sum_u_mirror[p]  = sum_u_mirror[p] + u[SumW-1:0];
        sum_v_mirror[p]  = sum_v_mirror[p] + v[SumW-1:0];
        sum_sq_mirror[p] = sum_sq_mirror[p] + SqSumW'(u * u + v * v);
      end
    end else begin
      res.result_point   = req.point_index;
      res.spread         = '0;
      res.spread_missing = 1'b0;
      n = members_n;
      if (missing_mirror[p] || n < 2) begin
        res.spread_missing = 1'b1;
      end else begin
        su  = longint'($signed(sum_u_mirror[p]));
        sv  = longint'($signed(sum_v_mirror[p]));
        num = longint'(n * longint'(sum_sq_mirror[p])) - (su * su + sv * sv);
        if (num > 0) begin
          q    = longint'(num) / (n * (n - 1));
          root = int_sqrt(q);
          res.spread = (root > 65535) ? 16'hFFFF : root[15:0];
        end
      end
      owed_spreads.push_back(res);
      sum_u_mirror[p]   = '0;
      sum_v_mirror[p]   = '0;
      sum_sq_mirror[p]  = '0;
      missing_mirror[p] = 1'b0;
    end
  endtask

  // Driver: the head of the queue is held on the port until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        apply_request(pending_reqs.pop_front());
      end
      if (!in_push || !in_full) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_push <= 1'b1;
          in_data <= pending_reqs[0];
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pops results with random stalls and checks each field.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (owed_spreads.size() == 0) begin
          report_mismatch($sformatf("unexpected result for point %0d",
                                    out_data.result_point));
        end else begin
          out_item_t exp_res;
          exp_res = owed_spreads.pop_front();
          if (out_data.result_point !== exp_res.result_point)
            report_mismatch($sformatf("result_point %0d, expected %0d",
                                      out_data.result_point, exp_res.result_point));
          if (out_data.spread !== exp_res.spread)
            report_mismatch($sformatf("spread %0d, expected %0d at point %0d",
                                      out_data.spread, exp_res.spread,
                                      exp_res.result_point));
          if (out_data.spread_missing !== exp_res.spread_missing)
            report_mismatch($sformatf("spread_missing %0b, expected %0b at point %0d",
                                      out_data.spread_missing, exp_res.spread_missing,
                                      exp_res.result_point));
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) pop_gap = $urandom_range(1, 12);
      end
    end
  end

  function automatic in_item_t make_req(input logic kind, input int unsigned pt,
                                        input int u, input int v, input logic miss);
    in_item_t it;
    it.req_type       = kind;
    it.point_index    = pt[PointW-1:0];
    it.u_sample       = u[SampleW-1:0];
    it.v_sample       = v[SampleW-1:0];
    it.sample_missing = miss;
    return it;
  endfunction

  // Waits until every request is sent and every result is back, then lets an
  // accumulate that is still in flight finish before the count is changed.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_push || owed_spreads.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_member_count(input logic [CountW-1:0] n);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    members_n = n;
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(0, 511) - 256;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // One well-formed ensemble at a point: a few members, then a compute.
  task automatic queue_ensemble(input int unsigned pt);
    int members;
    members = $urandom_range(1, 6);
    for (int m = 0; m < members; m++)
      pending_reqs.push_back(make_req(REQ_ACCUM, pt, rand_sample(), rand_sample(),
                                      $urandom_range(0, 11) == 0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, pt, rand_sample(), rand_sample(),
                                    1'($urandom_range(0, 1))));
  endtask

  initial begin
    logic [CountW-1:0] phase_n[5];
    int unsigned pt;
    int sent;

    for (int i = 0; i < Points; i++) begin
      sum_u_mirror[i]   = '0;
      sum_v_mirror[i]   = '0;
      sum_sq_mirror[i]  = '0;
      missing_mirror[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset count of two members.
    // Largest spread that still fits without clamping.
    pending_reqs.push_back(make_req(REQ_ACCUM, 0, 32767, 32767, 1'b0));
    pending_reqs.push_back(make_req(REQ_ACCUM, 0, -32768, -32768, 1'b0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, 0, 0, 0, 1'b0));
    // Three extreme members against n = 2 push the root past the clamp.
    pending_reqs.push_back(make_req(REQ_ACCUM, 16383, 32767, -32768, 1'b0));
    pending_reqs.push_back(make_req(REQ_ACCUM, 16383, -32768, 32767, 1'b0));
    pending_reqs.push_back(make_req(REQ_ACCUM, 16383, 32767, -32768, 1'b0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, 16383, -1, -1, 1'b1));
    // Identical members with too small a count give a negative variance.
    for (int i = 0; i < 4; i++)
      pending_reqs.push_back(make_req(REQ_ACCUM, 1, 256, -256, 1'b0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, 1, 0, 0, 1'b0));
    // A missing member marks the point; its sums stay untouched.
    pending_reqs.push_back(make_req(REQ_ACCUM, 2, 100, 100, 1'b1));
    pending_reqs.push_back(make_req(REQ_ACCUM, 2, 5, -5, 1'b0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, 2, 0, 0, 1'b0));
    // A compute on an untouched point, and a second one after the clear.
    pending_reqs.push_back(make_req(REQ_COMPUTE, 3, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, 2, 0, 0, 1'b0));
    wait_drained();

    // A count below two makes every spread missing.
    write_member_count(8'd1);
    pending_reqs.push_back(make_req(REQ_ACCUM, 4, 700, -300, 1'b0));
    pending_reqs.push_back(make_req(REQ_ACCUM, 4, -20, 40, 1'b0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, 4, 0, 0, 1'b0));
    wait_drained();
    write_member_count(8'd0);
    pending_reqs.push_back(make_req(REQ_ACCUM, 5, 1, 1, 1'b0));
    pending_reqs.push_back(make_req(REQ_COMPUTE, 5, 0, 0, 1'b0));
    wait_drained();

    // Random part, in phases with a new member count each. Every phase
    // drains fully before the next count is written.
    phase_n[0] = 8'd255;
    phase_n[1] = 8'd2;
    phase_n[2] = 8'($urandom_range(3, 254));
    phase_n[3] = 8'($urandom_range(0, 1));
    phase_n[4] = 8'($urandom_range(2, 8));
    for (int ph = 0; ph < 5; ph++) begin
      write_member_count(phase_n[ph]);
      if (ph == 4) quiet = 1'b1;
      sent = 0;
      while (sent < 125) begin
        case ($urandom_range(0, 9))
          0: pt = $urandom_range(0, Points - 1);
          1: pt = Points - 1;
          default: pt = $urandom_range(0, 15);
        endcase
        if ($urandom_range(0, 6) == 0) begin
          // Noise: a lone accumulate or a lone compute.
          pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), pt, rand_sample(),
                                          rand_sample(), 1'($urandom_range(0, 1))));
        end else begin
          queue_ensemble(pt);
        end
        sent = pending_reqs.size() + sent;
        while (pending_reqs.size() > 0) @(posedge clk);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/evs_pkg.sv
src/evs_front.sv
src/evs_back.sv
src/ensemble_vector_spread.sv
src/evs_checker.sv
dv/tb_ensemble_vector_spread.sv
